@@ rtl/graph_component_counter_core_defines.svh @@
// ----------------------------------------------------------------------------
// Graph component counter assertion macros
// Concurrent check helpers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef GRAPH_COMPONENT_COUNTER_CORE_DEFINES_SVH
`define GRAPH_COMPONENT_COUNTER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define GCC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcc check failed");

// next-cycle implication, disabled while reset is low
`define GCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcc check failed");

`endif

@@ rtl/gcc_pkg.sv @@
// ----------------------------------------------------------------------------
// Graph component counter package
// Shared codes, types and the lowest-set-bit search.
// ----------------------------------------------------------------------------
package gcc_pkg;

  localparam int VERTEX_W     = 6;
  localparam int COUNT_W      = 7;
  localparam int VERTEX_LIMIT = 64;
  localparam logic [COUNT_W-1:0] VCOUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_ADD_UNDIR,
    OP_ADD_DIR,
    OP_COUNT
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_ADDED,
    STAT_WRONG_KIND,
    STAT_RANGE,
    STAT_COUNT
  } status_e;

  typedef enum logic {
    REG_VERTEX_COUNT,
    REG_DIRECTED_MODE
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE_RD_A,
    S_EDGE_WR_A,
    S_EDGE_RD_B,
    S_EDGE_WR_B,
    S_CNT_SEEK,
    S_CNT_EXPAND,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic rd;
    logic wr;
  } adj_cmd_t;

  function automatic logic [VERTEX_W-1:0] first_set(input logic [VERTEX_LIMIT-1:0] vec);
    logic [VERTEX_W-1:0] idx;
    idx = '0;
    for (int i = VERTEX_LIMIT - 1; i >= 0; i--) begin
      if (vec[i]) idx = VERTEX_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ rtl/gcc_adj_mem.sv @@
// ----------------------------------------------------------------------------
// Adjacency row memory
// One row per vertex, one access a cycle, registered read, per-row valid bits.
// ----------------------------------------------------------------------------
module gcc_adj_mem
  import gcc_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  adj_cmd_t         cmd_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [DEPTH-1:0] wdata_i,
  output logic [DEPTH-1:0] rdata_o
);

  logic [DEPTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_valid_q;
  logic [DEPTH-1:0] rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) mem[addr_i] <= wdata_i;
    if (cmd_i.rd) rdata_q <= mem[addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (cmd_i.wr) row_valid_q[addr_i] <= 1'b1;
      if (cmd_i.rd) rvalid_q <= row_valid_q[addr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

@@ rtl/graph_component_counter_core.sv @@
// ----------------------------------------------------------------------------
// Graph component counter core
// Adjacency bit matrix with edge loads and a counted walk of separate trees.
// ----------------------------------------------------------------------------
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tuser opcode, tdata vertices
// m_axis    out        m_axis_tvalid/m_axis_tready  tuser status, tdata count
// cfg       in         cfg_we_i                     cfg_index_i, cfg_data_i
//
// Rejected edge: straight to result. Directed edge: read, write the from row;
// undirected edge: also the to row. Count: a seek and expand per vertex in use,
// one row read per expanded vertex through the single adjacency port and one
// lowest-bit search per step. Input ready only while idle; the output register
// holds one result. Reset clears the matrix at once through per-row valid bits.
// ----------------------------------------------------------------------------
module graph_component_counter_core
  import gcc_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // vertex_from[5:0], vertex_to[11:6]
  input  logic [1:0]          s_axis_tuser,   // opcode[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // component_count[6:0]
  output logic [1:0]          m_axis_tuser,   // status[1:0]
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [COUNT_W-1:0]  cfg_data_i
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam logic [COUNT_W-1:0] MaxV = COUNT_W'(MAX_VERTICES);

  state_e                   state_q, state_d;
  logic                     m_tvalid_q, m_tvalid_d;
  logic [7:0]               m_tdata_q, m_tdata_d;
  status_e                  m_tuser_q, m_tuser_d;
  logic [COUNT_W-1:0]       vertex_count_q;
  logic                     directed_q;

  opcode_e                  op_q, op_d;
  logic [VERTEX_W-1:0]      from_q, from_d, to_q, to_d;
  status_e                  status_q, status_d;
  logic [COUNT_W-1:0]       count_q, count_d;
  logic [MAX_VERTICES-1:0]  visited_q, visited_d, pending_q, pending_d;

  logic                     accept;
  opcode_e                  in_op;
  logic [VERTEX_W-1:0]      in_from, in_to;
  logic                     in_is_count;
  status_e                  in_status;
  logic [COUNT_W-1:0]       n_use;
  logic [MAX_VERTICES-1:0]  use_mask, unvisited, search_vec, fresh;
  logic [MAX_VERTICES-1:0]  from_bit, to_bit, idx_bit;
  logic                     pend_any, unvis_any, out_free;
  logic [AW-1:0]            idx;

  adj_cmd_t                 mem_cmd;
  logic [AW-1:0]            mem_addr;
  logic [MAX_VERTICES-1:0]  mem_wdata, mem_rdata;

  gcc_adj_mem #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW)
  ) u_adj_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (mem_cmd),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_op         = opcode_e'(s_axis_tuser);
  assign in_from       = s_axis_tdata[VERTEX_W-1:0];
  assign in_to         = s_axis_tdata[2*VERTEX_W-1:VERTEX_W];
  assign in_is_count   = (in_op != OP_ADD_UNDIR) && (in_op != OP_ADD_DIR);

  assign n_use = (vertex_count_q > MaxV) ? MaxV : vertex_count_q;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      use_mask[i] = (COUNT_W'(i) < n_use);
      from_bit[i] = (from_q == VERTEX_W'(i));
      to_bit[i]   = (to_q == VERTEX_W'(i));
      idx_bit[i]  = (idx == AW'(i));
    end
  end

  always_comb begin
    priority if (in_is_count) begin
      in_status = STAT_COUNT;
    end else if ((in_op == OP_ADD_DIR) != directed_q) begin
      in_status = STAT_WRONG_KIND;
    end else if (({1'b0, in_from} >= n_use) || ({1'b0, in_to} >= n_use)) begin
      in_status = STAT_RANGE;
    end else begin
      in_status = STAT_ADDED;
    end
  end

  assign unvisited  = ~visited_q & use_mask;
  assign pend_any   = |pending_q;
  assign unvis_any  = |unvisited;
  assign search_vec = pend_any ? pending_q : unvisited;
  assign idx        = AW'(first_set(VERTEX_LIMIT'(search_vec)));
  assign fresh      = mem_rdata & use_mask & ~visited_q;
  assign out_free   = !m_tvalid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (in_status == STAT_COUNT) state_d = S_CNT_SEEK;
          else if (in_status == STAT_ADDED) state_d = S_EDGE_RD_A;
          else state_d = S_RESULT;
        end
      end
      S_EDGE_RD_A:  state_d = S_EDGE_WR_A;
      S_EDGE_WR_A:  state_d = (op_q == OP_ADD_UNDIR) ? S_EDGE_RD_B : S_RESULT;
      S_EDGE_RD_B:  state_d = S_EDGE_WR_B;
      S_EDGE_WR_B:  state_d = S_RESULT;
      S_CNT_SEEK:   state_d = (pend_any || unvis_any) ? S_CNT_EXPAND : S_RESULT;
      S_CNT_EXPAND: state_d = S_CNT_SEEK;
      S_RESULT:     if (out_free) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d       = op_q;
    from_d     = from_q;
    to_d       = to_q;
    status_d   = status_q;
    count_d    = count_q;
    visited_d  = visited_q;
    pending_d  = pending_q;
    m_tvalid_d = m_tvalid_q && !m_axis_tready;
    m_tdata_d  = m_tdata_q;
    m_tuser_d  = m_tuser_q;
    mem_cmd    = '0;
    mem_addr   = '0;
    mem_wdata  = mem_rdata;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d      = in_op;
          from_d    = in_from;
          to_d      = in_to;
          status_d  = in_status;
          count_d   = '0;
          visited_d = '0;
          pending_d = '0;
        end
      end
      S_EDGE_RD_A: begin
        mem_cmd.rd = 1'b1;
        mem_addr   = from_q[AW-1:0];
      end
      S_EDGE_WR_A: begin
        mem_cmd.wr = 1'b1;
        mem_addr   = from_q[AW-1:0];
        mem_wdata  = mem_rdata | to_bit;
      end
      S_EDGE_RD_B: begin
        mem_cmd.rd = 1'b1;
        mem_addr   = to_q[AW-1:0];
      end
      S_EDGE_WR_B: begin
        mem_cmd.wr = 1'b1;
        mem_addr   = to_q[AW-1:0];
        mem_wdata  = mem_rdata | from_bit;
      end
      S_CNT_SEEK: begin
        mem_cmd.rd = pend_any || unvis_any;
        mem_addr   = idx;
        if (pend_any) begin
          pending_d = pending_q & ~idx_bit;
        end else if (unvis_any) begin
          visited_d = visited_q | idx_bit;
          count_d   = count_q + COUNT_W'(1);
        end
      end
      S_CNT_EXPAND: begin
        visited_d = visited_q | fresh;
        pending_d = pending_q | fresh;
      end
      S_RESULT: begin
        if (out_free) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {1'b0, count_q};
          m_tuser_d  = status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      m_tvalid_q     <= 1'b0;
      vertex_count_q <= VCOUNT_RESET;
      directed_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_VERTEX_COUNT:  vertex_count_q <= cfg_data_i;
          REG_DIRECTED_MODE: directed_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    from_q    <= from_d;
    to_q      <= to_d;
    status_q  <= status_d;
    count_q   <= count_d;
    visited_q <= visited_d;
    pending_q <= pending_d;
    m_tdata_q <= m_tdata_d;
    m_tuser_q <= m_tuser_d;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

endmodule

@@ rtl/gcc_checker.sv @@
// ----------------------------------------------------------------------------
// Graph component counter port checker
// Port-level checks on the request and result channels, bound to the core.
// ----------------------------------------------------------------------------
`include "graph_component_counter_core_defines.svh"

module gcc_checker
  import gcc_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [7:0]   m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  `GCC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  `GCC_ASSERT_NEXT(a_busy_after_request, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  `GCC_ASSERT_IMPLY(a_count_zero_on_edge, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != STAT_COUNT), m_axis_tdata == 8'd0)

  `GCC_ASSERT_IMPLY(a_count_bound, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata <= 8'(MAX_VERTICES))

endmodule

bind graph_component_counter_core gcc_checker #(
  .MAX_VERTICES (MAX_VERTICES)
) u_gcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/sv/graph_component_counter_checker.sv @@
// ----------------------------------------------------------------------------
// Graph component counter checker
// Watches the request, result and register channels, keeps its own copy of
// the adjacency matrix and settings, predicts status and tree count for each
// accepted request, and compares every accepted result in order.
// ----------------------------------------------------------------------------
module graph_component_counter_checker
  import gcc_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [15:0]        s_tdata_i,   // vertex_from[5:0], vertex_to[11:6]
  input  logic [1:0]         s_tuser_i,   // opcode[1:0]
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [7:0]         m_tdata_i,   // component_count[6:0]
  input  logic [1:0]         m_tuser_i,   // status[1:0]
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [COUNT_W-1:0] cfg_data_i,
  output int                 mismatches_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e            status;
    logic [COUNT_W-1:0] count;
  } answer_t;

  logic [VERTEX_LIMIT-1:0] adj_rows [MAX_VERTICES];
  logic [COUNT_W-1:0]      vertex_count;
  logic                    directed;
  answer_t                 answers_q [$];
  answer_t                 want;

  function automatic int vertices_active();
    return (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
  endfunction

  function automatic logic [COUNT_W-1:0] count_trees();
    int n;
    logic [VERTEX_LIMIT-1:0] mask, seen, reach, front, grow;
    logic [COUNT_W-1:0] trees;
    n = vertices_active();
    mask = (n >= VERTEX_LIMIT) ? '1 : ((64'd1 << n) - 64'd1);
    seen = '0;
    trees = '0;
    for (int i = 0; i < n; i++) begin
      if (!seen[i]) begin
        reach = 64'd1 << i;
        front = reach;
        while (front != '0) begin
          grow = '0;
          for (int j = 0; j < MAX_VERTICES; j++) begin
            if (front[j]) grow |= adj_rows[j];
          end
          front = grow & mask & ~seen & ~reach;
          reach |= front;
        end
        seen |= reach;
        trees++;
      end
    end
    return trees;
  endfunction

  function automatic answer_t apply_request(logic [1:0] op, logic [VERTEX_W-1:0] a,
                                            logic [VERTEX_W-1:0] b);
    answer_t ans;
    int n;
    n = vertices_active();
    ans.count = '0;
    if (op >= OP_COUNT) begin
      ans.count  = count_trees();
      ans.status = STAT_COUNT;
    end else if ((op == OP_ADD_DIR) != directed) begin
      ans.status = STAT_WRONG_KIND;
    end else if (int'(a) >= n || int'(b) >= n) begin
      ans.status = STAT_RANGE;
    end else begin
      adj_rows[a][b] = 1'b1;
      if (op == OP_ADD_UNDIR) adj_rows[b][a] = 1'b1;
      ans.status = STAT_ADDED;
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_VERTICES; r++) adj_rows[r] = '0;
      vertex_count = VCOUNT_RESET;
      directed     = 1'b0;
      answers_q.delete();
      mismatches_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (answers_q.size() == 0) begin
          $error("result with status %0d arrived with no request waiting", m_tuser_i);
          mismatches_o++;
        end else begin
          want = answers_q.pop_front();
          if (m_tuser_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser_i);
            mismatches_o++;
          end
          if (m_tdata_i !== 8'(want.count)) begin
            $error("component_count: expected %0d, got %0d", want.count, m_tdata_i);
            mismatches_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        answers_q.push_back(apply_request(s_tuser_i, s_tdata_i[5:0], s_tdata_i[11:6]));
      end
      if (cfg_we_i) begin
        if (cfg_index_i == REG_VERTEX_COUNT) vertex_count = cfg_data_i;
        else directed = cfg_data_i[0];
      end
    end
    pending_o = answers_q.size();
  end

endmodule

@@ tb/sv/graph_component_counter_core_tb.sv @@
// ----------------------------------------------------------------------------
// Graph component counter testbench
// Drives edge loads and count requests through several register settings
// and handshake pacing phases; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module graph_component_counter_core_tb;
  import gcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         MAX_VERTICES  = 64;
  localparam int         QUIET_LIMIT   = 5000;
  localparam logic [1:0] OP_COUNT_ALT  = 2'd3;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               s_axis_tvalid  = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata   = '0;  // vertex_from[5:0], vertex_to[11:6]
  logic [1:0]         s_axis_tuser   = '0;  // opcode[1:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready  = 1'b0;
  logic [7:0]         m_axis_tdata;         // component_count[6:0]
  logic [1:0]         m_axis_tuser;         // status[1:0]
  logic               cfg_we         = 1'b0;
  cfg_reg_e           cfg_index      = REG_VERTEX_COUNT;
  logic [COUNT_W-1:0] cfg_data       = '0;

  int                 mismatches;
  int                 pending;
  int                 send_gap_pct   = 0;
  int                 recv_stall_pct = 0;
  int                 quiet_cycles   = 0;
  int                 edges_sent     = 0;
  int                 counts_sent    = 0;
  int                 settings_made  = 0;
  logic [COUNT_W-1:0] cur_vc         = VCOUNT_RESET;
  logic               cur_dir        = 1'b0;

  graph_component_counter_core #(.MAX_VERTICES(MAX_VERTICES)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  graph_component_counter_checker #(.MAX_VERTICES(MAX_VERTICES)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic issue_request(logic [1:0] op, logic [VERTEX_W-1:0] a,
                               logic [VERTEX_W-1:0] b);
    @(negedge clk_i);
    if ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_gap_pct) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, b, a};
    s_axis_tuser  <= op;
    if (op >= OP_COUNT) counts_sent++;
    else edges_sent++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // drop the valid, then hold off until every result is back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_config(logic [COUNT_W-1:0] vc, logic dir);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_VERTEX_COUNT;
    cfg_data  <= vc;
    @(negedge clk_i);
    cfg_index <= REG_DIRECTED_MODE;
    cfg_data  <= COUNT_W'(dir);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    cur_vc    = vc;
    cur_dir   = dir;
    settings_made++;
  endtask

  task automatic run_random_graph(int items);
    int r;
    int n;
    logic [1:0] op;
    logic [VERTEX_W-1:0] a, b;
    n = (cur_vc > MAX_VERTICES) ? MAX_VERTICES : int'(cur_vc);
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(99);
      if (r < 15) begin
        op = ($urandom_range(3) == 0) ? OP_COUNT_ALT : OP_COUNT;
        a  = VERTEX_W'($urandom_range(63));
        b  = VERTEX_W'($urandom_range(63));
      end else if (r < 85 && n > 0) begin
        op = cur_dir ? OP_ADD_DIR : OP_ADD_UNDIR;
        a  = VERTEX_W'($urandom_range(n - 1));
        b  = ($urandom_range(3) == 0) ? a : VERTEX_W'($urandom_range(n - 1));
      end else begin
        op = $urandom_range(1) ? OP_ADD_DIR : OP_ADD_UNDIR;
        a  = VERTEX_W'($urandom_range(63));
        b  = VERTEX_W'($urandom_range(63));
      end
      issue_request(op, a, b);
    end
  endtask

  initial begin
    int gap_pct   [4];
    int stall_pct [4];
    int r;
    logic [COUNT_W-1:0] vc;

    gap_pct   = '{0, 80, 0, 30};
    stall_pct = '{0, 0, 80, 30};

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: undirected, all vertices in use
    issue_request(OP_COUNT, 6'd0, 6'd0);
    issue_request(OP_ADD_UNDIR, 6'd0, 6'd63);
    issue_request(OP_ADD_UNDIR, 6'd63, 6'd63);
    issue_request(OP_ADD_UNDIR, 6'd0, 6'd63);
    issue_request(OP_ADD_DIR, 6'd5, 6'd6);
    issue_request(OP_COUNT_ALT, 6'd63, 6'd63);

    set_config(7'd0, 1'b0);
    issue_request(OP_ADD_UNDIR, 6'd0, 6'd0);
    issue_request(OP_COUNT, 6'd21, 6'd42);
    issue_request(OP_ADD_DIR, 6'd63, 6'd63);

    set_config(7'd127, 1'b1);
    issue_request(OP_ADD_DIR, 6'd63, 6'd0);
    issue_request(OP_ADD_UNDIR, 6'd1, 6'd2);
    issue_request(OP_ADD_DIR, 6'd10, 6'd11);
    issue_request(OP_COUNT, 6'd0, 6'd0);

    set_config(7'd2, 1'b0);
    issue_request(OP_ADD_UNDIR, 6'd1, 6'd2);
    issue_request(OP_ADD_UNDIR, 6'd0, 6'd1);
    issue_request(OP_COUNT, 6'd0, 6'd0);

    set_config(7'd1, 1'b1);
    issue_request(OP_ADD_DIR, 6'd0, 6'd0);
    issue_request(OP_ADD_DIR, 6'd0, 6'd1);
    issue_request(OP_COUNT, 6'd0, 6'd0);
    issue_request(OP_COUNT_ALT, 6'd0, 6'd0);

    set_config(7'd64, 1'b0);
    issue_request(OP_ADD_UNDIR, 6'd42, 6'd21);
    issue_request(OP_COUNT, 6'd0, 6'd0);

    for (int p = 0; p < 4; p++) begin
      drain_results();
      send_gap_pct   = gap_pct[p];
      recv_stall_pct = stall_pct[p];
      for (int s = 0; s < 2; s++) begin
        r = $urandom_range(19);
        unique case (r)
          0: begin
            vc = 7'd0;
          end
          1: begin
            vc = 7'd127;
          end
          2: begin
            vc = 7'd1;
          end
          3, 4, 5, 6: begin
            vc = 7'd64;
          end
          default: begin
            vc = COUNT_W'($urandom_range(63, 2));
          end
        endcase
        set_config(vc, 1'($urandom_range(1)));
        run_random_graph(88);
      end
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    $display("Sent %0d requests: %0d edge loads and %0d count requests",
             edges_sent + counts_sent, edges_sent, counts_sent);
    $display("Covered %0d register settings over four pacing phases of gaps and stalls",
             settings_made);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
